FILE: rtl/core/plbuf_pkg.sv
// Shared types, codes and helpers for the LED strip pixel buffer.
// Used by every file in rtl/core; depends on nothing else.
package plbuf_pkg;

  // Default sizes of the buffer.
  localparam int LED_MAX_DEF     = 256;
  localparam int STRIP_COUNT_DEF = 16;

  // The store is split into four byte banks by address bits 1..0.
  localparam int BANKS  = 4;
  // One bank word holds the raw byte (15..8) and the scaled byte (7..0).
  localparam int WORD_W = 16;

  // Operation codes of an input item.
  localparam logic [1:0] KIND_SET  = 2'd0;
  localparam logic [1:0] KIND_FILL = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_COLOR_ORDER = 2'd0;
  localparam logic [1:0] CFG_BRIGHTNESS  = 2'd1;
  localparam logic [1:0] CFG_LED_COUNT   = 2'd2;

  // Configuration reset values.
  localparam logic [7:0] COLOR_ORDER_RST = 8'd82;
  localparam logic [7:0] BRIGHTNESS_RST  = 8'd0;
  localparam logic [8:0] LED_COUNT_RST   = 9'd0;

  // Color channels, in the order their bytes are written.
  localparam logic [1:0] CH_W = 2'd0;
  localparam logic [1:0] CH_R = 2'd1;
  localparam logic [1:0] CH_G = 2'd2;
  localparam logic [1:0] CH_B = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         strip;
    logic signed [15:0] start_index;
    logic signed [15:0] end_index;
    logic [31:0]        color;
    logic [9:0]         byte_address;
  } item_t;

  typedef struct packed {
    logic [8:0] pixels_written;
    logic       show_request;
    logic [7:0] raw_byte;
    logic [7:0] scaled_byte;
  } result_t;

  // Write request for one bank while a pixel is written.
  typedef struct packed {
    logic       we;
    logic [1:0] chan;
    logic [8:0] row_ofs;
  } bank_wr_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_WRITE,
    ST_READ
  } state_t;

  // Picks the byte of one channel out of a packed WRGB word.
  function automatic logic [7:0] chan_byte(logic [31:0] c, logic [1:0] ch);
    logic [7:0] v;
    case (ch)
      CH_W:    v = c[31:24];
      CH_R:    v = c[23:16];
      CH_G:    v = c[15:8];
      default: v = c[7:0];
    endcase
    return v;
  endfunction

  // Brightness scaling; a brightness of zero leaves the value as it is.
  function automatic logic [7:0] scale_byte(logic [7:0] v, logic [7:0] br);
    logic [15:0] p;
    p = v * br;
    return (br == 8'd0) ? v : p[15:8];
  endfunction

endpackage

FILE: rtl/core/led_strip_pixel_buffer.sv
// LED strip pixel buffer: set, fill and read of per-strip raw and scaled pixel stores.
// A read goes through SETUP and READ before its result is registered; a set or fill
// goes through SETUP and then WRITE for its pixels; one that writes nothing ends at SETUP.
// Throughput: one pixel per cycle, set by the single write port of each byte bank.
// A new item is taken in the cycle its predecessor's result is shown; done is one cycle.
// Reset: a clearing pass over all STRIP_COUNT * LED_MAX rows (4096 by default) keeps busy high.
module led_strip_pixel_buffer #(
  parameter int LED_MAX     = plbuf_pkg::LED_MAX_DEF,
  parameter int STRIP_COUNT = plbuf_pkg::STRIP_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  plbuf_pkg::item_t   item,
  output logic               done,
  output plbuf_pkg::result_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);

  localparam int DEPTH       = STRIP_COUNT * LED_MAX;
  localparam int RW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int STRIP_BYTES = LED_MAX * 4;
  localparam int NB          = plbuf_pkg::BANKS;

  plbuf_pkg::state_t state, state_next;

  // Configuration registers.
  logic [7:0] color_order;
  logic [7:0] brightness;
  logic [8:0] led_count;

  // Item registers.
  plbuf_pkg::item_t item_q;
  logic             strip_ok;
  logic [RW-1:0]    strip_base;
  logic [RW-1:0]    clear_row;
  logic [8:0]       idx;
  logic [8:0]       remain;
  logic [8:0]       written;
  logic             show;
  logic [31:0]      sc_color;
  logic             rd_ok;
  logic [1:0]       rd_bank;

  // Range planning.
  logic [8:0]  n;
  logic [15:0] su;
  logic        neg;
  logic [15:0] ra, rb, lo, hi, last;
  logic [8:0]  plan_first;
  logic [8:0]  plan_cnt;
  logic        plan_show;

  // Control and memory signals.
  logic                   finish;
  plbuf_pkg::result_t     res_next;
  plbuf_pkg::bank_wr_t [NB-1:0] wr;
  logic [NB-1:0]          mem_we;
  logic [NB-1:0][RW-1:0]  mem_addr;
  logic [NB-1:0][plbuf_pkg::WORD_W-1:0] mem_wdata;
  logic [NB-1:0][plbuf_pkg::WORD_W-1:0] mem_rdata;
  logic [RW-1:0]          rd_row;

  assign cfg_ready = 1'b1;

  // Configuration writes are taken at any time.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_order <= plbuf_pkg::COLOR_ORDER_RST;
      brightness  <= plbuf_pkg::BRIGHTNESS_RST;
      led_count   <= plbuf_pkg::LED_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        plbuf_pkg::CFG_COLOR_ORDER: color_order <= cfg_data[7:0];
        plbuf_pkg::CFG_BRIGHTNESS:  brightness  <= cfg_data[7:0];
        plbuf_pkg::CFG_LED_COUNT:   led_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Range of pixels an item writes: first pixel, count and show flag.
  always_comb begin
    n   = (32'(led_count) < LED_MAX) ? led_count : 9'(LED_MAX);
    su  = item_q.start_index;
    neg = item_q.start_index[15] | item_q.end_index[15];
    ra  = neg ? 16'd0 : item_q.start_index;
    rb  = neg ? (16'(n) - 16'd1) : item_q.end_index;
    lo  = (ra < rb) ? ra : rb;
    hi  = (ra < rb) ? rb : ra;
    last = (hi >= 16'(n)) ? (16'(n) - 16'd1) : hi;

    plan_first = 9'd0;
    plan_cnt   = 9'd0;
    plan_show  = 1'b0;
    if (strip_ok) begin
      case (item_q.kind)
        plbuf_pkg::KIND_SET: begin
          plan_show  = 1'b1;
          plan_first = su[8:0];
          plan_cnt   = (su < 16'(n)) ? 9'd1 : 9'd0;
        end
        plbuf_pkg::KIND_FILL: begin
          if (n != 9'd0) begin
            plan_show  = 1'b1;
            plan_first = lo[8:0];
            plan_cnt   = (lo >= 16'(n)) ? 9'd0 : 9'(last - lo + 16'd1);
          end
        end
        default: ;
      endcase
    end
  end

  // Next state, busy and the cycle in which a result is produced.
  always_comb begin
    state_next = state;
    finish     = 1'b0;
    res_next   = '0;
    case (state)
      plbuf_pkg::ST_CLEAR: begin
        if (clear_row == RW'(DEPTH - 1)) begin
          state_next = plbuf_pkg::ST_IDLE;
        end
      end
      plbuf_pkg::ST_IDLE: begin
        if (start) begin
          state_next = plbuf_pkg::ST_SETUP;
        end
      end
      plbuf_pkg::ST_SETUP: begin
        if (item_q.kind == plbuf_pkg::KIND_READ) begin
          state_next = plbuf_pkg::ST_READ;
        end else if (plan_cnt == 9'd0) begin
          state_next            = plbuf_pkg::ST_IDLE;
          finish                = 1'b1;
          res_next.show_request = plan_show;
        end else begin
          state_next = plbuf_pkg::ST_WRITE;
        end
      end
      plbuf_pkg::ST_WRITE: begin
        if (remain == 9'd1) begin
          state_next              = plbuf_pkg::ST_IDLE;
          finish                  = 1'b1;
          res_next.pixels_written = written;
          res_next.show_request   = show;
        end
      end
      plbuf_pkg::ST_READ: begin
        state_next = plbuf_pkg::ST_IDLE;
        finish     = 1'b1;
        if (rd_ok) begin
          res_next.raw_byte    = mem_rdata[rd_bank][15:8];
          res_next.scaled_byte = mem_rdata[rd_bank][7:0];
        end
      end
      default: state_next = plbuf_pkg::ST_IDLE;
    endcase
    busy = (state != plbuf_pkg::ST_IDLE);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= plbuf_pkg::ST_CLEAR;
      clear_row <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
      if (state == plbuf_pkg::ST_CLEAR) begin
        clear_row <= clear_row + RW'(1);
      end
    end
  end

  // Item payload registers.
  always_ff @(posedge clk) begin
    if (state == plbuf_pkg::ST_IDLE && start) begin
      item_q     <= item;
      strip_ok   <= (int'(item.strip) < STRIP_COUNT);
      strip_base <= RW'(int'(item.strip) * LED_MAX);
    end
    if (state == plbuf_pkg::ST_SETUP) begin
      idx      <= plan_first;
      remain   <= plan_cnt;
      written  <= plan_cnt;
      show     <= plan_show;
      sc_color <= {plbuf_pkg::scale_byte(item_q.color[31:24], brightness),
                   plbuf_pkg::scale_byte(item_q.color[23:16], brightness),
                   plbuf_pkg::scale_byte(item_q.color[15:8], brightness),
                   plbuf_pkg::scale_byte(item_q.color[7:0], brightness)};
      rd_ok    <= strip_ok && (int'(item_q.byte_address) < STRIP_BYTES);
      rd_bank  <= item_q.byte_address[1:0];
    end
    if (state == plbuf_pkg::ST_WRITE) begin
      idx    <= idx + 9'd1;
      remain <= remain - 9'd1;
    end
    if (finish) begin
      result <= res_next;
    end
  end

  // Bank writes for the current pixel.
  plbuf_map u_map (
    .color_order (color_order),
    .idx         (idx),
    .wr          (wr)
  );

  assign rd_row = strip_base + RW'(item_q.byte_address[9:2]);

  // Bank port control: clearing pass, pixel writes, or the read address.
  always_comb begin
    for (int b = 0; b < NB; b++) begin
      mem_we[b]    = 1'b0;
      mem_addr[b]  = rd_row;
      mem_wdata[b] = '0;
      if (state == plbuf_pkg::ST_CLEAR) begin
        mem_we[b]   = 1'b1;
        mem_addr[b] = clear_row;
      end else if (state == plbuf_pkg::ST_WRITE) begin
        mem_we[b]    = wr[b].we;
        mem_addr[b]  = strip_base + RW'(wr[b].row_ofs);
        mem_wdata[b] = {plbuf_pkg::chan_byte(item_q.color, wr[b].chan),
                        plbuf_pkg::chan_byte(sc_color, wr[b].chan)};
      end
    end
  end

  plbuf_mem #(
    .DEPTH (DEPTH),
    .RW    (RW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

FILE: rtl/core/plbuf_mem.sv
// Banked pixel store: four single-port byte banks, each word holding raw and scaled bytes.
// Depends on plbuf_pkg for the bank count and word width.
module plbuf_mem #(
  parameter int DEPTH = plbuf_pkg::LED_MAX_DEF * plbuf_pkg::STRIP_COUNT_DEF,
  parameter int RW    = $clog2(DEPTH)
) (
  input  logic                                            clk,
  input  logic [plbuf_pkg::BANKS-1:0]                     we,
  input  logic [plbuf_pkg::BANKS-1:0][RW-1:0]             addr,
  input  logic [plbuf_pkg::BANKS-1:0][plbuf_pkg::WORD_W-1:0] wdata,
  output logic [plbuf_pkg::BANKS-1:0][plbuf_pkg::WORD_W-1:0] rdata
);

  for (genvar g = 0; g < plbuf_pkg::BANKS; g++) begin : g_bank
    logic [plbuf_pkg::WORD_W-1:0] ram [DEPTH];
    logic [plbuf_pkg::WORD_W-1:0] rdata_q;

    // One access per bank and cycle; read data is registered.
    always_ff @(posedge clk) begin
      if (we[g]) begin
        ram[addr[g]] <= wdata[g];
      end
      rdata_q <= ram[addr[g]];
    end

    assign rdata[g] = rdata_q;
  end

endmodule

FILE: rtl/core/plbuf_map.sv
// Maps one pixel index and the color order onto per-bank byte writes.
// Depends on plbuf_pkg for channel codes and the bank write struct.
module plbuf_map (
  input  logic [7:0]                                  color_order,
  input  logic [8:0]                                  idx,
  output plbuf_pkg::bank_wr_t [plbuf_pkg::BANKS-1:0]  wr
);

  logic [1:0]  offs [4];
  logic        stride4;
  logic [10:0] pix;
  logic [10:0] pa [4];

  always_comb begin
    // Byte offsets of W, R, G and B inside a pixel.
    offs[plbuf_pkg::CH_W] = color_order[7:6];
    offs[plbuf_pkg::CH_R] = color_order[5:4];
    offs[plbuf_pkg::CH_G] = color_order[3:2];
    offs[plbuf_pkg::CH_B] = color_order[1:0];

    // Equal white and red offsets mean three bytes per pixel without white.
    stride4 = (offs[plbuf_pkg::CH_W] != offs[plbuf_pkg::CH_R]);
    pix     = stride4 ? {idx, 2'b00} : ({1'b0, idx, 1'b0} + {2'b00, idx});

    for (int ch = 0; ch < 4; ch++) begin
      pa[ch] = pix + {9'd0, offs[ch]};
    end

    // The byte addresses lie within four consecutive bytes, so each lands in
    // its own bank unless two offsets are equal; then the later channel wins.
    for (int b = 0; b < plbuf_pkg::BANKS; b++) begin
      wr[b] = '0;
      for (int ch = 0; ch < 4; ch++) begin
        if ((2'(ch) != plbuf_pkg::CH_W || stride4) && pa[ch][1:0] == 2'(b)) begin
          wr[b].we      = 1'b1;
          wr[b].chan    = 2'(ch);
          wr[b].row_ofs = pa[ch][10:2];
        end
      end
    end
  end

endmodule

FILE: rtl/core/plbuf_chk.sv
// Port-level checker for the LED strip pixel buffer, bound to the top level.
// Depends on plbuf_pkg for the result struct.
module plbuf_chk (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input plbuf_pkg::result_t result
);

  // An accepted beat keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low right after an accepted beat");

  // A result is shown only once the block is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // Each item passes through SETUP after IDLE, so results never come back to back.
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results in consecutive cycles");

  // Pixels are written only together with a show request.
  a_write_show: assert property (@(posedge clk) disable iff (rst)
    (done && !result.show_request) |-> (result.pixels_written == 9'd0))
    else $error("pixels written without a show request");

  // Read data never comes with a write result.
  a_read_only: assert property (@(posedge clk) disable iff (rst)
    (done && (result.raw_byte != 8'd0 || result.scaled_byte != 8'd0))
      |-> (result.pixels_written == 9'd0 && !result.show_request))
    else $error("read data mixed with a write result");

endmodule

bind led_strip_pixel_buffer plbuf_chk u_plbuf_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

FILE: bench/tb_led_strip_pixel_buffer.sv
// Testbench for led_strip_pixel_buffer: directed and random set, fill and read beats,
// checked against a behavioral mirror of the raw and scaled pixel stores.
// Depends on plbuf_pkg and the led_strip_pixel_buffer RTL only.
module tb_led_strip_pixel_buffer;
  timeunit 1ns;
  timeprecision 1ps;
  import plbuf_pkg::*;

  localparam int LED_MAX      = LED_MAX_DEF;
  localparam int STRIP_COUNT  = STRIP_COUNT_DEF;
  localparam int STRIP_BYTES  = LED_MAX * 4;
  localparam int STORE_BYTES  = STRIP_COUNT * STRIP_BYTES;
  localparam int RANDOM_ITEMS = 1250;
  // Operation code that the block leaves without effect.
  localparam logic [1:0] KIND_NONE = 2'd3;

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic       busy;
  item_t      item;
  logic       done;
  result_t    result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;

  // Mirror of the block: both byte stores and the three registers.
  logic [7:0] raw_mirror    [STORE_BYTES];
  logic [7:0] scaled_mirror [STORE_BYTES];
  logic [7:0] color_order_q;
  logic [7:0] brightness_q;
  logic [8:0] led_count_q;

  result_t expected_results [$];
  int      error_count = 0;

  led_strip_pixel_buffer DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Pixel count actually in use on a strip.
  function automatic int pixels_in_use();
    return (led_count_q < LED_MAX) ? int'(led_count_q) : LED_MAX;
  endfunction

  function automatic logic [7:0] brightness_scale(logic [7:0] v);
    logic [15:0] prod;
    prod = 16'(v) * 16'(brightness_q);
    return (brightness_q == 8'd0) ? v : prod[15:8];
  endfunction

  function automatic void store_byte(int addr, logic [7:0] v);
    if (addr < STORE_BYTES) begin
      raw_mirror[addr]    = v;
      scaled_mirror[addr] = brightness_scale(v);
    end
  endfunction

  // Channel bytes go out white, red, green, blue; a later one wins on a shared offset.
  function automatic void paint_pixel(int strip_no, int idx, logic [31:0] c);
    int wo, ro, go, bo, stride, base;
    wo = color_order_q[7:6];
    ro = color_order_q[5:4];
    go = color_order_q[3:2];
    bo = color_order_q[1:0];
    stride = (wo == ro) ? 3 : 4;
    base = strip_no * STRIP_BYTES + idx * stride;
    if (stride == 4) store_byte(base + wo, c[31:24]);
    store_byte(base + ro, c[23:16]);
    store_byte(base + go, c[15:8]);
    store_byte(base + bo, c[7:0]);
  endfunction

  // Applies one beat to the mirror and returns the result it must produce.
  function automatic result_t pixel_buffer_outcome(item_t it);
    result_t r;
    int n, su, st, en, last, swap;
    r = '0;
    n = pixels_in_use();
    if (int'(it.strip) < STRIP_COUNT) begin
      case (it.kind)
        KIND_SET: begin
          su = int'({16'd0, it.start_index});
          if (su < n) begin
            paint_pixel(it.strip, su, it.color);
            r.pixels_written = 9'd1;
          end
          r.show_request = 1'b1;
        end
        KIND_FILL: begin
          if (n > 0) begin
            st = $signed(it.start_index);
            en = $signed(it.end_index);
            // A negative bound selects the whole strip.
            if (st < 0 || en < 0) begin
              st = 0;
              en = n - 1;
            end
            if (en < st) begin
              swap = en;
              en = st;
              st = swap;
            end
            if (st > n) st = n;
            if (en > n) en = n;
            last = (en < n - 1) ? en : n - 1;
            for (int i = st; i <= last; i++) begin
              paint_pixel(it.strip, i, it.color);
              r.pixels_written = r.pixels_written + 9'd1;
            end
            r.show_request = 1'b1;
          end
        end
        KIND_READ: begin
          if (int'(it.byte_address) < STRIP_BYTES) begin
            r.raw_byte    = raw_mirror[it.strip * STRIP_BYTES + it.byte_address];
            r.scaled_byte = scaled_mirror[it.strip * STRIP_BYTES + it.byte_address];
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic void report_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Each done strobe carries one result; match it with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got %h", $time, result);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        report_field("pixels_written", want.pixels_written, result.pixels_written);
        report_field("show_request", want.show_request, result.show_request);
        report_field("raw_byte", want.raw_byte, result.raw_byte);
        report_field("scaled_byte", want.scaled_byte, result.scaled_byte);
      end
    end
  end

  // Mostly back to back, sometimes a short pause, now and then a long one.
  function automatic int draw_gap(bit quiet);
    int pick;
    pick = $urandom_range(99);
    if (quiet || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one beat and holds it until the block takes it.
  task automatic send_item(item_t it);
    @(negedge clk);
    start = 1'b1;
    item  = it;
    do @(posedge clk); while (busy);
    expected_results.push_back(pixel_buffer_outcome(it));
  endtask

  task automatic pause_items(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // Waits until every result is back and the block has settled.
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] data);
    repeat ($urandom_range(0, 3)) @(negedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_COLOR_ORDER: color_order_q = data[7:0];
      CFG_BRIGHTNESS:  brightness_q  = data[7:0];
      CFG_LED_COUNT:   led_count_q   = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic item_t make_item(logic [1:0] kind, logic [3:0] strip_no,
                                      logic [15:0] first, logic [15:0] last,
                                      logic [31:0] c, logic [9:0] addr);
    item_t it;
    it.kind         = kind;
    it.strip        = strip_no;
    it.start_index  = first;
    it.end_index    = last;
    it.color        = c;
    it.byte_address = addr;
    return it;
  endfunction

  // Random beat aimed at the pixels in use, with some out-of-range and noise.
  function automatic item_t random_item(int n, logic [3:0] hot_strip);
    item_t it;
    int pick, addr_lim;
    it = make_item(2'($urandom()), 4'($urandom()), 16'($urandom()), 16'($urandom()),
                   $urandom(), 10'($urandom()));
    pick = $urandom_range(99);
    if (pick < 35) it.kind = KIND_SET;
    else if (pick < 60) it.kind = KIND_FILL;
    else if (pick < 95) it.kind = KIND_READ;
    else it.kind = KIND_NONE;
    if ($urandom_range(3) != 0) it.strip = hot_strip;
    case (it.kind)
      KIND_SET: begin
        if ($urandom_range(6) != 0) it.start_index = 16'($urandom_range(n));
      end
      KIND_FILL: begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          it.start_index = 16'($urandom_range(n + 2));
          it.end_index   = 16'($urandom_range(n + 2));
        end else if (pick < 75) begin
          it.end_index = -16'sd1 - 16'($urandom_range(40));
        end
      end
      KIND_READ: begin
        addr_lim = n * 4 + 3;
        if (addr_lim > 1023) addr_lim = 1023;
        if ($urandom_range(4) != 0) it.byte_address = 10'($urandom_range(addr_lim));
      end
      default: ;
    endcase
    return it;
  endfunction

  // Stores read as zero after reset; with no pixels in use a set still
  // requests a show, a fill does not, and the unused code does nothing.
  task automatic test_after_reset();
    send_item(make_item(KIND_READ, 4'd0, 16'd0, 16'd0, 32'd0, 10'd0));
    send_item(make_item(KIND_READ, 4'd15, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 10'd1023));
    send_item(make_item(KIND_SET, 4'd2, 16'd0, 16'd0, 32'h1234_5678, 10'd0));
    pause_items(3);
    send_item(make_item(KIND_FILL, 4'd2, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 10'd0));
    send_item(make_item(KIND_NONE, 4'd15, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 10'h3FF));
  endtask

  // Single pixels in the reset color order, in and out of range.
  task automatic test_set_pixel();
    drain_results();
    write_reg(CFG_LED_COUNT, 9'd4);
    send_item(make_item(KIND_SET, 4'd3, 16'd0, 16'd0, 32'hFF11_2233, 10'd0));
    send_item(make_item(KIND_SET, 4'd3, 16'd3, 16'd0, 32'h00FF_FFFF, 10'd0));
    send_item(make_item(KIND_SET, 4'd3, 16'd4, 16'd0, 32'hAAAA_AAAA, 10'd0));
    send_item(make_item(KIND_SET, 4'd3, 16'hFFFF, 16'd0, 32'h5555_5555, 10'd0));
    send_item(make_item(KIND_READ, 4'd3, 16'd0, 16'd0, 32'd0, 10'd0));
    pause_items(1);
    send_item(make_item(KIND_READ, 4'd3, 16'd0, 16'd0, 32'd0, 10'd1));
    send_item(make_item(KIND_READ, 4'd3, 16'd0, 16'd0, 32'd0, 10'd10));
  endtask

  // Four-byte order at full brightness: reversed, negative and oversized bounds.
  task automatic test_fill_range();
    drain_results();
    write_reg(CFG_COLOR_ORDER, 9'h01B);
    write_reg(CFG_BRIGHTNESS, 9'd255);
    write_reg(CFG_LED_COUNT, 9'd8);
    send_item(make_item(KIND_FILL, 4'd5, 16'd6, 16'd2, 32'hFFFF_FFFF, 10'd0));
    send_item(make_item(KIND_FILL, 4'd5, -16'sd5, 16'd3, 32'h8040_2010, 10'd0));
    send_item(make_item(KIND_FILL, 4'd5, 16'd5, 16'd300, 32'h0000_0000, 10'd0));
    send_item(make_item(KIND_READ, 4'd5, 16'd0, 16'd0, 32'd0, 10'd31));
    send_item(make_item(KIND_READ, 4'd5, 16'd0, 16'd0, 32'd0, 10'd0));
  endtask

  // Three-byte orders whose offset of three lands in the next pixel.
  task automatic test_offset_spill();
    drain_results();
    write_reg(CFG_COLOR_ORDER, 9'h0F3);
    write_reg(CFG_BRIGHTNESS, 9'd1);
    send_item(make_item(KIND_SET, 4'd7, 16'd1, 16'd0, 32'h00AA_BBCC, 10'd0));
    send_item(make_item(KIND_READ, 4'd7, 16'd0, 16'd0, 32'd0, 10'd6));
    send_item(make_item(KIND_READ, 4'd7, 16'd0, 16'd0, 32'd0, 10'd3));
    drain_results();
    write_reg(CFG_COLOR_ORDER, 9'h0FF);
    write_reg(CFG_BRIGHTNESS, 9'd128);
    send_item(make_item(KIND_SET, 4'd7, 16'd0, 16'd0, 32'h11FE_8001, 10'd0));
    send_item(make_item(KIND_READ, 4'd7, 16'd0, 16'd0, 32'd0, 10'd3));
    drain_results();
    write_reg(CFG_COLOR_ORDER, 9'h100);
  endtask

  // A full strip, and a count above LED_MAX that is cut to it.
  task automatic test_count_clamp();
    drain_results();
    write_reg(CFG_COLOR_ORDER, {1'b0, COLOR_ORDER_RST});
    write_reg(CFG_BRIGHTNESS, {1'b0, BRIGHTNESS_RST});
    write_reg(CFG_LED_COUNT, 9'd256);
    send_item(make_item(KIND_FILL, 4'd15, 16'hFFFF, 16'hFFFF, 32'hDEAD_BEEF, 10'd0));
    drain_results();
    write_reg(CFG_LED_COUNT, 9'd511);
    send_item(make_item(KIND_SET, 4'd15, 16'd255, 16'd0, 32'h0102_0304, 10'd0));
    send_item(make_item(KIND_READ, 4'd15, 16'd0, 16'd0, 32'd0, 10'd767));
  endtask

  // Phases of random traffic, each under a fresh register setting.
  task automatic test_random_traffic();
    int sent, phase_len, pick, n;
    logic [7:0] order;
    logic [3:0] hot_strip;
    bit quiet;
    item_t it;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_results();
      order = 8'($urandom());
      if ($urandom_range(2) == 0) order[5:4] = order[7:6];
      write_reg(CFG_COLOR_ORDER, {1'($urandom()), order});
      pick = $urandom_range(9);
      write_reg(CFG_BRIGHTNESS, {1'($urandom()),
                (pick < 2) ? 8'd0 : (pick == 2) ? 8'd255 : 8'($urandom())});
      pick = $urandom_range(19);
      if (pick < 2) write_reg(CFG_LED_COUNT, 9'd0);
      else if (pick < 4) write_reg(CFG_LED_COUNT, 9'd256);
      else if (pick == 4) write_reg(CFG_LED_COUNT, 9'($urandom_range(257, 511)));
      else write_reg(CFG_LED_COUNT, 9'($urandom_range(1, 40)));
      n = pixels_in_use();
      phase_len = $urandom_range(40, 120);
      quiet = ($urandom_range(3) == 0);
      hot_strip = 4'($urandom());
      repeat (phase_len) begin
        it = random_item(n, hot_strip);
        send_item(it);
        if (it.kind != KIND_NONE) sent++;
        pause_items(draw_gap(quiet));
      end
    end
  endtask

  initial begin
    foreach (raw_mirror[i]) begin
      raw_mirror[i]    = 8'd0;
      scaled_mirror[i] = 8'd0;
    end
    color_order_q = COLOR_ORDER_RST;
    brightness_q  = BRIGHTNESS_RST;
    led_count_q   = LED_COUNT_RST;
    rst       = 1'b1;
    start     = 1'b0;
    item      = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_COLOR_ORDER;
    cfg_data  = 9'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_after_reset();
    test_set_pixel();
    test_fill_range();
    test_offset_spill();
    test_count_clamp();
    test_random_traffic();

    drain_results();
    repeat (16) @(posedge clk);
    if (error_count == 0)
      $display("tb_led_strip_pixel_buffer: done, clean");
    else
      $display("tb_led_strip_pixel_buffer: done, errors");
    $finish;
  end

  // Backstop against a hung handshake.
  initial begin
    #8_000_000;
    $display("tb_led_strip_pixel_buffer: done, errors");
    $finish;
  end

endmodule
